### design/rpi_pkg.sv
// ----------------------------------------------------------------------------
// Ray/plane intersection package
// Widths, status codes, register indexes and pipeline sideband types.
// ----------------------------------------------------------------------------
package rpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 32;               // Q16.16 positions
    localparam int VEC_W     = 18;               // Q1.16 directions / normal
    localparam int EPS_W     = 16;
    localparam int DIFF_W    = POS_W + 1;        // point - origin
    localparam int DEN_P_W   = 2 * VEC_W;        // one normal * direction term
    localparam int NUM_P_W   = DIFF_W + VEC_W;   // one diff * normal term
    localparam int DEN_W     = DEN_P_W + 2;      // sum of three terms
    localparam int NUM_W     = NUM_P_W + 2;
    localparam int DN_W      = DEN_W - 1;        // |denominator|
    localparam int NM_W      = NUM_W - 1;        // |numerator|
    localparam int MAG_W     = VEC_W;            // |direction|
    localparam int PP_SPLIT  = NM_W / 2;
    localparam int PP_W      = MAG_W + PP_SPLIT;
    localparam int PROD_W    = MAG_W + NM_W;     // |d| * |num|
    localparam int QUO_W     = 40;               // quotient bits kept
    localparam int HEAD_W    = PROD_W - QUO_W;   // dividend above the quotient
    localparam int SUM_W     = QUO_W + 2;
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES = QUO_W / DIV_STEPS_PER_STAGE;
    localparam int FRONT_STAGES = 6;
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_BEHIND   = 2'd2
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POINT_X  = 3'd0,
        REG_POINT_Y  = 3'd1,
        REG_POINT_Z  = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5,
        REG_EPSILON  = 3'd6
    } cfg_reg_t;

    // Per-ray data that rides alongside the dividers
    typedef struct packed {
        status_t                   status;
        logic [2:0]                neg;
        logic [2:0]                big;
        logic [2:0][POS_W-1:0]     org;
    } side_t;

endpackage

### design/rpi_divider.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned quotient of {head, low} / dn, a fixed number of bits per stage.
// ----------------------------------------------------------------------------
module rpi_divider (
    input  logic                        aclk,
    input  logic                        ce,
    input  logic [rpi_pkg::DN_W-1:0]    in_rem,
    input  logic [rpi_pkg::QUO_W-1:0]   in_low,
    input  logic [rpi_pkg::DN_W-1:0]    in_dn,
    output logic [rpi_pkg::QUO_W-1:0]   out_quo
);
    import rpi_pkg::*;

    logic [DN_W-1:0]  rem_pipe [DIV_STAGES+1];
    logic [QUO_W-1:0] acc_pipe [DIV_STAGES+1];
    logic [DN_W-1:0]  dn_pipe  [DIV_STAGES+1];
    logic [DN_W-1:0]  rem_next [DIV_STAGES];
    logic [QUO_W-1:0] acc_next [DIV_STAGES];

    assign rem_pipe[0] = in_rem;
    assign acc_pipe[0] = in_low;
    assign dn_pipe[0]  = in_dn;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        always_comb begin : p_step
            logic [DN_W:0]    trial;
            logic [DN_W-1:0]  r;
            logic [QUO_W-1:0] a;
            logic             qb;
            r = rem_pipe[s];
            a = acc_pipe[s];
            for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
                // shift the next dividend bit in, quotient bit out at the bottom
                trial = {r, a[QUO_W-1]};
                qb    = (trial >= {1'b0, dn_pipe[s]});
                r     = qb ? DN_W'(trial - {1'b0, dn_pipe[s]}) : trial[DN_W-1:0];
                a     = {a[QUO_W-2:0], qb};
            end
            rem_next[s] = r;
            acc_next[s] = a;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_pipe[s+1] <= rem_next[s];
                acc_pipe[s+1] <= acc_next[s];
                dn_pipe[s+1]  <= dn_pipe[s];
            end
        end
    end

    assign out_quo = acc_pipe[DIV_STAGES];

endmodule

### design/ray_plane_intersection.sv
// ----------------------------------------------------------------------------
// Ray/plane intersection
// Intersects a stream of rays with a plane held in configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   s_ carries one ray per transaction (origin Q16.16, direction Q1.16).
//   m_ returns one result per ray, in order: a status code and the hit point.
//   The plane (point, normal) and the parallel threshold are written on the
//   cfg_ port while no ray is in flight; reset loads point 0, normal +Y,
//   threshold 7.
// Timing:
//   A ray accepted on s_ passes through six front stages (difference,
//   products, sums, classify, partial products, merge), twenty divider
//   stages of two quotient bits each, and the output register to m_.
//   One ray per cycle is accepted when m_ is not stalled.
// Stalls:
//   The whole pipeline holds while m_tvalid is high and m_tready low;
//   s_tready drops in the same cycle, nothing is lost or repeated.
//   Reset clears all valid bits; data in flight is dropped.
// ----------------------------------------------------------------------------
module ray_plane_intersection (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 2 zero bits
    input  logic [rpi_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, hit_x, hit_y, hit_z, 6 zero bits
    output logic [rpi_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                              cfg_we,
    input  logic [rpi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rpi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import rpi_pkg::*;

    localparam int PIPE_N = FRONT_STAGES + DIV_STAGES;

    // configuration
    logic signed [POS_W-1:0] pt_reg  [3];
    logic signed [VEC_W-1:0] nrm_reg [3];
    logic [EPS_W-1:0]        eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_reg[0]  <= '0;
            pt_reg[1]  <= '0;
            pt_reg[2]  <= '0;
            nrm_reg[0] <= '0;
            nrm_reg[1] <= VEC_W'(1 << FRAC_BITS);
            nrm_reg[2] <= '0;
            eps_reg    <= EPS_W'(7);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_POINT_X:  pt_reg[0]  <= cfg_wdata[POS_W-1:0];
                REG_POINT_Y:  pt_reg[1]  <= cfg_wdata[POS_W-1:0];
                REG_POINT_Z:  pt_reg[2]  <= cfg_wdata[POS_W-1:0];
                REG_NORMAL_X: nrm_reg[0] <= cfg_wdata[VEC_W-1:0];
                REG_NORMAL_Y: nrm_reg[1] <= cfg_wdata[VEC_W-1:0];
                REG_NORMAL_Z: nrm_reg[2] <= cfg_wdata[VEC_W-1:0];
                REG_EPSILON:  eps_reg    <= cfg_wdata[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic              ce;
    logic              m_tvalid_reg;
    logic [PIPE_N-1:0] vld_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            vld_reg      <= {vld_reg[PIPE_N-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[PIPE_N-1];
        end
    end

    // unpack input
    logic signed [POS_W-1:0] in_org [3];
    logic signed [VEC_W-1:0] in_dir [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_org[i] = s_tdata[i*POS_W +: POS_W];
            in_dir[i] = s_tdata[3*POS_W + i*VEC_W +: VEC_W];
        end
    end

    // stage 1: point - origin
    logic signed [DIFF_W-1:0] s1_diff_reg [3];
    logic signed [VEC_W-1:0]  s1_dir_reg  [3];
    logic [2:0][POS_W-1:0]    s1_org_reg;
    // stage 2: products
    logic signed [DEN_P_W-1:0] s2_denp_reg [3];
    logic signed [NUM_P_W-1:0] s2_nump_reg [3];
    logic signed [VEC_W-1:0]   s2_dir_reg  [3];
    logic [2:0][POS_W-1:0]     s2_org_reg;
    // stage 3: sums
    logic signed [DEN_W-1:0]   s3_den_reg;
    logic signed [NUM_W-1:0]   s3_num_reg;
    logic signed [VEC_W-1:0]   s3_dir_reg [3];
    logic [2:0][POS_W-1:0]     s3_org_reg;
    // stage 4: classify, magnitudes
    side_t                     s4_side_reg;
    logic [DN_W-1:0]           s4_dn_reg;
    logic [NM_W-1:0]           s4_nm_reg;
    logic [MAG_W-1:0]          s4_dm_reg [3];
    // stage 5: partial products
    side_t                     s5_side_reg;
    logic [DN_W-1:0]           s5_dn_reg;
    logic [PP_W-1:0]           s5_pplo_reg [3];
    logic [MAG_W+NM_W-PP_SPLIT-1:0] s5_pphi_reg [3];
    // stage 6: full product, overflow check
    side_t                     s6_side_reg;
    logic [DN_W-1:0]           s6_dn_reg;
    logic [HEAD_W-1:0]         s6_head_reg [3];
    logic [QUO_W-1:0]          s6_low_reg  [3];

    logic signed [DEN_W-1:0] s4_den;
    logic signed [NUM_W-1:0] s4_num;
    logic [DN_W-1:0]         s4_dn_next;
    logic [NM_W-1:0]         s4_nm_next;
    logic                    s4_par, s4_behind;
    logic [PROD_W-1:0]       s6_prod [3];

    always_comb begin
        s4_den     = s3_den_reg;
        s4_num     = s3_num_reg;
        s4_dn_next = s4_den[DEN_W-1] ? DN_W'(-s4_den) : DN_W'(s4_den);
        s4_nm_next = s4_num[NUM_W-1] ? NM_W'(-s4_num) : NM_W'(s4_num);
        s4_par     = (s4_den == '0) ||
                     (s4_dn_next < DN_W'({eps_reg, {FRAC_BITS{1'b0}}}));
        s4_behind  = (s4_num != '0) && (s4_num[NUM_W-1] != s4_den[DEN_W-1]);
        for (int i = 0; i < 3; i++) begin
            s6_prod[i] = PROD_W'(s5_pplo_reg[i]) + {s5_pphi_reg[i], {PP_SPLIT{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 3; i++) begin
                s1_diff_reg[i] <= DIFF_W'(pt_reg[i]) - DIFF_W'(in_org[i]);
                s1_dir_reg[i]  <= in_dir[i];
                s1_org_reg[i]  <= in_org[i];

                s2_denp_reg[i] <= DEN_P_W'(s1_dir_reg[i]) * DEN_P_W'(nrm_reg[i]);
                s2_nump_reg[i] <= NUM_P_W'(s1_diff_reg[i]) * NUM_P_W'(nrm_reg[i]);
                s2_dir_reg[i]  <= s1_dir_reg[i];

                s3_dir_reg[i]  <= s2_dir_reg[i];

                s4_dm_reg[i]   <= s3_dir_reg[i][VEC_W-1] ? MAG_W'(-s3_dir_reg[i])
                                                         : MAG_W'(s3_dir_reg[i]);
                s4_side_reg.neg[i] <= s3_dir_reg[i][VEC_W-1] ^ s4_num[NUM_W-1]
                                      ^ s4_den[DEN_W-1];

                s5_pplo_reg[i] <= PP_W'(s4_dm_reg[i]) * PP_W'(s4_nm_reg[PP_SPLIT-1:0]);
                s5_pphi_reg[i] <= (MAG_W+NM_W-PP_SPLIT)'(s4_dm_reg[i])
                                  * (MAG_W+NM_W-PP_SPLIT)'(s4_nm_reg[NM_W-1:PP_SPLIT]);

                s6_head_reg[i] <= s6_prod[i][PROD_W-1:QUO_W];
                s6_low_reg[i]  <= s6_prod[i][QUO_W-1:0];
            end
            s2_org_reg <= s1_org_reg;
            s3_org_reg <= s2_org_reg;
            s3_den_reg <= DEN_W'(s2_denp_reg[0]) + DEN_W'(s2_denp_reg[1])
                          + DEN_W'(s2_denp_reg[2]);
            s3_num_reg <= NUM_W'(s2_nump_reg[0]) + NUM_W'(s2_nump_reg[1])
                          + NUM_W'(s2_nump_reg[2]);

            s4_side_reg.status <= s4_par ? ST_PARALLEL : (s4_behind ? ST_BEHIND : ST_HIT);
            s4_side_reg.big    <= '0;
            s4_side_reg.org    <= s3_org_reg;
            s4_dn_reg          <= s4_dn_next;
            s4_nm_reg          <= s4_nm_next;

            s5_side_reg <= s4_side_reg;
            s5_dn_reg   <= s4_dn_reg;

            s6_side_reg.status <= s5_side_reg.status;
            s6_side_reg.neg    <= s5_side_reg.neg;
            s6_side_reg.org    <= s5_side_reg.org;
            for (int i = 0; i < 3; i++) begin
                // quotient needs more than QUO_W bits: saturate
                s6_side_reg.big[i] <= DN_W'(s6_prod[i][PROD_W-1:QUO_W]) >= s5_dn_reg;
            end
            s6_dn_reg <= s5_dn_reg;
        end
    end

    // dividers, one per axis
    logic [QUO_W-1:0] quo [3];
    for (genvar g = 0; g < 3; g++) begin : g_axis
        rpi_divider u_div (
            .aclk    (aclk),
            .ce      (ce),
            .in_rem  (DN_W'(s6_head_reg[g])),
            .in_low  (s6_low_reg[g]),
            .in_dn   (s6_dn_reg),
            .out_quo (quo[g])
        );
    end

    side_t side_reg [DIV_STAGES];
    always_ff @(posedge aclk) begin
        if (ce) begin
            side_reg[0] <= s6_side_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // final: sign, add origin, saturate
    side_t                   fin_side;
    logic signed [SUM_W-1:0] fin_sum [3];
    logic [2:0][POS_W-1:0]   fin_hit;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_next;

    always_comb begin
        fin_side = side_reg[DIV_STAGES-1];
        for (int i = 0; i < 3; i++) begin
            fin_sum[i] = SUM_W'($signed(fin_side.org[i]))
                         + (fin_side.neg[i] ? -SUM_W'(quo[i]) : SUM_W'(quo[i]));
            if (fin_side.status != ST_HIT) begin
                fin_hit[i] = '0;
            end else if (fin_side.big[i]) begin
                fin_hit[i] = fin_side.neg[i] ? {1'b1, {(POS_W-1){1'b0}}}
                                             : {1'b0, {(POS_W-1){1'b1}}};
            end else if (fin_sum[i][SUM_W-1:POS_W-1] != '0 &&
                         fin_sum[i][SUM_W-1:POS_W-1] != '1) begin
                fin_hit[i] = fin_sum[i][SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                                 : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                fin_hit[i] = fin_sum[i][POS_W-1:0];
            end
        end
        m_tdata_next = OUT_TDATA_W'({fin_hit[2], fin_hit[1], fin_hit[0], fin_side.status});
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tdata_reg[1:0] != ST_HIT) |-> (m_tdata_reg[97:2] == '0))
        else $error("miss result carries a nonzero point");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted ray did not enter the pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> (vld_reg == $past(vld_reg)))
        else $error("pipeline valid bits moved during a stall");

endmodule
